### rtl/rqp_pkg.sv
// Shared types and constants of the recirculating song queue.
// Used by the front decoder, the command queue and the execute unit.
package rqp_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int PLAYLIST_COUNT_DEF = 16;
  localparam int SONG_ID_MAX        = 1024;
  localparam int PLAYLIST_LEN       = 3;

  localparam int ID_W     = 10;
  localparam int FUNC_W   = 3;
  localparam int PL_W     = 4;
  localparam int SLOT_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 2;
  localparam int SCNT_W   = 11;

  // command codes on the input word
  localparam logic [FUNC_W-1:0] FN_PLAY   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_TOGGLE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ADDPL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LOAD   = 3'd4;

  // status codes on the result word
  localparam logic [STATUS_W-1:0] ST_PLAYED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOOP_ON  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOOP_OFF = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd7;

  // classified operation handed from the front to the execute unit
  typedef enum logic [2:0] {
    OP_PLAY,
    OP_TOGGLE,
    OP_ADD,
    OP_ADDPL,
    OP_LOAD,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   song_id;
    logic [PL_W-1:0]   playlist_index;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  // input word layout, lowest field last
  typedef struct packed {
    logic [4:0]        pad;
    logic [SLOT_W-1:0] slot;
    logic [PL_W-1:0]   playlist_index;
    logic [ID_W-1:0]   song_id;
    logic [FUNC_W-1:0] func;
  } in_word_t;

  // result word layout, lowest field last
  typedef struct packed {
    logic               loop_on;
    logic [COUNT_W-1:0] added_count;
    logic [ID_W-1:0]    played_id;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

### rtl/recirculating_queue_with_playlists_core.sv
// Recirculating song queue with playlists: top level.
// Instantiates rqp_front, rqp_cmd_queue and rqp_exec; depends on rqp_pkg.
//
// Each input word is one command and yields exactly one result word, in
// order. Words are decoded and checked on entry and wait in a two-entry
// command queue, so input keeps flowing while a result waits, until the
// queue fills. Toggle, add, load, invalid and empty-queue play load the
// result from idle; non-empty play first reads the queue memory;
// add-playlist reads the table, then pushes one entry per cycle until
// the row ends or the queue fills. A command starts only when the result
// register is free by the next edge. The user must write song_count via
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module recirculating_queue_with_playlists_core #(
  parameter int QUEUE_DEPTH    = rqp_pkg::QUEUE_DEPTH_DEF,
  parameter int PLAYLIST_COUNT = rqp_pkg::PLAYLIST_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rqp_pkg::SCNT_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // func[2:0], song_id[12:3], playlist_index[16:13], slot[18:17], zero[23:19]
  input  logic [23:0]               in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[2:0], played_id[12:3], added_count[14:13], loop_on[15]
  output logic [15:0]               out_tdata
);
  import rqp_pkg::*;

  logic cq_full;
  logic cq_push;
  cmd_t cq_in;
  logic cq_pop;
  logic cq_valid;
  cmd_t cq_out;

  rqp_front #(
    .PLAYLIST_COUNT (PLAYLIST_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cq_full   (cq_full),
    .cq_push   (cq_push),
    .cq_cmd    (cq_in)
  );

  rqp_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cq_push),
    .push_cmd  (cq_in),
    .full      (cq_full),
    .pop       (cq_pop),
    .cmd_valid (cq_valid),
    .cmd       (cq_out)
  );

  rqp_exec #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .PLAYLIST_COUNT (PLAYLIST_COUNT)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cq_valid),
    .cmd        (cq_out),
    .cmd_pop    (cq_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/rqp_front.sv
// Front decoder: holds the song_count register, checks ids and indexes
// and turns each input word into a classified command. Depends on rqp_pkg.
module rqp_front #(
  parameter int PLAYLIST_COUNT = rqp_pkg::PLAYLIST_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rqp_pkg::SCNT_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,
  input  logic                      cq_full,
  output logic                      cq_push,
  output rqp_pkg::cmd_t             cq_cmd
);
  import rqp_pkg::*;

  logic [SCNT_W-1:0] song_count_r;
  in_word_t          w;
  logic              id_ok;
  logic              pl_ok;
  logic              slot_ok;
  op_t               op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_count_r <= SCNT_W'(SONG_ID_MAX);
    end else if (cfg_we) begin
      song_count_r <= cfg_wdata;
    end
  end

  assign w       = in_word_t'(in_tdata);
  assign id_ok   = {1'b0, w.song_id} < song_count_r;
  assign pl_ok   = 32'(w.playlist_index) < PLAYLIST_COUNT;
  assign slot_ok = w.slot < SLOT_W'(PLAYLIST_LEN);

  always_comb begin
    case (w.func)
      FN_PLAY:   op = OP_PLAY;
      FN_TOGGLE: op = OP_TOGGLE;
      FN_ADD:    op = id_ok ? OP_ADD : OP_BAD;
      FN_ADDPL:  op = pl_ok ? OP_ADDPL : OP_BAD;
      FN_LOAD:   op = (pl_ok && slot_ok && id_ok) ? OP_LOAD : OP_BAD;
      default:   op = OP_BAD;
    endcase
  end

  assign in_tready             = !cq_full;
  assign cq_push               = in_tvalid && !cq_full;
  assign cq_cmd.op             = op;
  assign cq_cmd.song_id        = w.song_id;
  assign cq_cmd.playlist_index = w.playlist_index;
  assign cq_cmd.slot           = w.slot;

endmodule

### rtl/rqp_cmd_queue.sv
// Two-entry command queue between the front decoder and the execute unit.
// Depends on rqp_pkg for the command type.
module rqp_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rqp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          cmd_valid,
  output rqp_pkg::cmd_t cmd
);
  import rqp_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full      = cnt_r == 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/rqp_exec.sv
// Execute unit: song queue memory, playlist table memory, loop mode and
// the result register. Depends on rqp_pkg.
module rqp_exec #(
  parameter int QUEUE_DEPTH    = rqp_pkg::QUEUE_DEPTH_DEF,
  parameter int PLAYLIST_COUNT = rqp_pkg::PLAYLIST_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  rqp_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata
);
  import rqp_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TD  = PLAYLIST_COUNT * PLAYLIST_LEN;
  localparam int TAW = $clog2(TD);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PLAY = 3'b010,
    S_PLST = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [QAW-1:0]  head_r, head_nxt;
  logic [QAW-1:0]  tail_r, tail_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic            loop_r, loop_nxt;
  logic [1:0]      k_r, k_nxt;
  logic [TAW-1:0]  base_r, base_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            res_r;

  logic [ID_W-1:0] q_mem_r [QUEUE_DEPTH];
  logic [ID_W-1:0] t_mem_r [TD];
  logic [ID_W-1:0] q_rdata_r;
  logic [ID_W-1:0] t_rdata_r;

  logic            q_we, q_re;
  logic [ID_W-1:0] q_wdata;
  logic            t_we, t_re;
  logic [TAW-1:0]  t_waddr, t_raddr;
  logic [TAW-1:0]  cmd_base;
  logic            full, out_free, start;
  logic            res_ld;
  res_t            res_nxt;

  function automatic logic [QAW-1:0] adv(input logic [QAW-1:0] p);
    return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = fill_r == FW'(QUEUE_DEPTH);
  assign out_free = !out_valid_r || out_tready;
  // start only when the result register is free by the next edge; nothing
  // else loads it until this command finishes
  assign start    = (state_r == S_IDLE) && cmd_valid && out_free;
  assign cmd_pop  = start;
  assign cmd_base = TAW'(({4'b0, cmd.playlist_index} * 8'd3));

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    loop_nxt  = loop_r;
    k_nxt     = k_r;
    base_nxt  = base_r;
    q_we      = 1'b0;
    q_re      = 1'b0;
    q_wdata   = cmd.song_id;
    t_we      = 1'b0;
    t_re      = 1'b0;
    t_waddr   = cmd_base + TAW'(cmd.slot);
    t_raddr   = cmd_base;
    res_ld    = 1'b0;
    res_nxt.status      = ST_INVALID;
    res_nxt.played_id   = '0;
    res_nxt.added_count = '0;
    res_nxt.loop_on     = loop_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (cmd.op)
            OP_PLAY: begin
              if (fill_r == '0) begin
                res_ld         = 1'b1;
                res_nxt.status = ST_EMPTY;
              end else begin
                q_re      = 1'b1;
                state_nxt = S_PLAY;
              end
            end
            OP_TOGGLE: begin
              loop_nxt        = !loop_r;
              res_ld          = 1'b1;
              res_nxt.status  = loop_nxt ? ST_LOOP_ON : ST_LOOP_OFF;
              res_nxt.loop_on = loop_nxt;
            end
            OP_ADD: begin
              res_ld = 1'b1;
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                q_we                = 1'b1;
                tail_nxt            = adv(tail_r);
                fill_nxt            = fill_r + 1'b1;
                res_nxt.status      = ST_ADDED;
                res_nxt.added_count = COUNT_W'(1);
              end
            end
            OP_ADDPL: begin
              t_re      = 1'b1;
              base_nxt  = cmd_base;
              k_nxt     = 2'd0;
              state_nxt = S_PLST;
            end
            OP_LOAD: begin
              t_we           = 1'b1;
              res_ld         = 1'b1;
              res_nxt.status = ST_STORED;
            end
            default: begin
              res_ld         = 1'b1;
              res_nxt.status = ST_INVALID;
            end
          endcase
        end
      end
      S_PLAY: begin
        // pop the head; with loop on, write it straight back on the tail
        head_nxt          = adv(head_r);
        res_ld            = 1'b1;
        res_nxt.status    = ST_PLAYED;
        res_nxt.played_id = q_rdata_r;
        q_wdata           = q_rdata_r;
        if (loop_r) begin
          q_we                = 1'b1;
          tail_nxt            = adv(tail_r);
          res_nxt.added_count = COUNT_W'(1);
        end else begin
          fill_nxt = fill_r - 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_PLST: begin
        q_wdata = t_rdata_r;
        if (full) begin
          res_ld              = 1'b1;
          res_nxt.status      = ST_FULL;
          res_nxt.added_count = k_r;
          state_nxt           = S_IDLE;
        end else begin
          q_we     = 1'b1;
          tail_nxt = adv(tail_r);
          fill_nxt = fill_r + 1'b1;
          if (k_r == 2'(PLAYLIST_LEN - 1)) begin
            res_ld              = 1'b1;
            res_nxt.status      = ST_ADDED;
            res_nxt.added_count = COUNT_W'(PLAYLIST_LEN);
            state_nxt           = S_IDLE;
          end else begin
            // fetch the next entry of the row while this one is pushed
            k_nxt   = k_r + 2'd1;
            t_re    = 1'b1;
            t_raddr = base_r + TAW'(k_nxt);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem_r[tail_r] <= q_wdata;
    end
    if (q_re) begin
      q_rdata_r <= q_mem_r[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      t_mem_r[t_waddr] <= cmd.song_id;
    end
    if (t_re) begin
      t_rdata_r <= t_mem_r[t_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) begin
      res_r <= res_nxt;
    end
    k_r    <= k_nxt;
    base_r <= base_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      loop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      loop_r      <= loop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) |-> (fill_r == '0 || fill_r == FW'(QUEUE_DEPTH)))
    else $error("head and tail meet with a partly filled queue");

  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    (res_ld && res_nxt.status == ST_EMPTY) |-> (fill_r == '0))
    else $error("empty reported with words queued");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_ld |-> out_free)
    else $error("result register overwritten before it was taken");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLST) |-> (k_r < 2'(PLAYLIST_LEN)))
    else $error("playlist entry counter past row length");

endmodule
